// ----- rtl/dafmt_pkg.sv -----
// Package for the decimal ASCII formatter.
// Holds field widths, character constants and the control struct of the
// shift-and-add-3 unit; no dependencies.
package dafmt_pkg;

	localparam int VALUE_W        = 31;  // width of the binary input value
	localparam int S_DATA_W       = 32;  // value padded to whole bytes
	localparam int CHAR_W         = 6;   // width of one digit character code
	localparam int M_DATA_W       = 8;   // character padded to one byte
	localparam int VALUE_DIGITS   = 10;  // decimal digits of the largest value
	localparam int MAX_DIGITS_DEF = 10;  // default emit limit
	localparam int BCD_W          = 4;   // bits per BCD digit

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 6'd48;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_NINE   = 6'd57;  // '9'
	localparam logic [BCD_W-1:0]  BCD_ADJ_MIN = 4'd5;
	localparam logic [BCD_W-1:0]  BCD_ADJ     = 4'd3;

	// control from the sequencer to the conversion unit
	typedef struct packed {
		logic load;  // take a new value, clear the BCD digits
		logic step;  // one add-3 / shift iteration
	} dabble_ctrl_t;

endpackage

// ----- rtl/decimal_ascii_formatter_unit.sv -----
// Top level of the decimal ASCII formatter: sequencer and output register.
// Depends on dafmt_pkg and dafmt_dabble.
//
// Takes one unsigned 31-bit value per request on the s_ stream and sends its
// decimal digits as ASCII codes '0'..'9' on the m_ stream, most significant
// first, leading zeros dropped, m_tlast on the least significant digit. Zero
// gives the single character '0'. A value with more digits than MAX_DIGITS
// sends only its MAX_DIGITS low digits, inner zeros kept. After a request
// is accepted, the add-3/shift unit consumes one input bit per cycle; the
// scan for the first nonzero digit then drops the leading zeros, and the
// characters follow back to back while m_tready stays high. Skipped zeros
// plus characters always add up to MAX_DIGITS, so the time from one accept
// to the next does not depend on the value, apart from m_tready stalls.
// s_tready is high only while the block is idle, i.e. after the last
// character of a request is taken.
module decimal_ascii_formatter_unit #(
	parameter int MAX_DIGITS = dafmt_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request: [30:0] value, [31] zero pad (ignored)
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dafmt_pkg::S_DATA_W-1:0]  s_tdata,
	// result: [5:0] digit_char, [7:6] zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dafmt_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast   // last_digit
);

	// BCD register covers every digit of the value and the emit window
	localparam int BCD_DIGITS = (MAX_DIGITS > dafmt_pkg::VALUE_DIGITS) ?
		MAX_DIGITS : dafmt_pkg::VALUE_DIGITS;
	localparam int IDX_W = $clog2(BCD_DIGITS);
	localparam int CNT_W = $clog2(dafmt_pkg::VALUE_W + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;  // shift-add-3 iterations
	localparam logic [1:0] ST_SKIP = 2'd2;  // drop leading zeros
	localparam logic [1:0] ST_EMIT = 2'd3;  // characters out

	localparam logic [IDX_W-1:0] IDX_ONE = {{(IDX_W-1){1'b0}}, 1'b1};
	localparam logic [CNT_W-1:0] CNT_ONE = {{(CNT_W-1){1'b0}}, 1'b1};

	logic [1:0]                           state_q;
	logic [CNT_W-1:0]                     cnt_q;
	logic [IDX_W-1:0]                     ptr_q;
	logic                                 m_valid_q;
	logic                                 m_last_q;
	logic [dafmt_pkg::CHAR_W-1:0]         m_char_q;

	dafmt_pkg::dabble_ctrl_t              dctrl;
	logic [BCD_DIGITS*dafmt_pkg::BCD_W-1:0] bcd;

	logic                                 s_fire;
	logic                                 m_fire;
	logic                                 above;     // nonzero digit past the window
	logic [IDX_W-1:0]                     ptr_dec;
	logic [IDX_W-1:0]                     rd_idx;
	logic [dafmt_pkg::BCD_W-1:0]          rd_digit;
	logic [dafmt_pkg::CHAR_W-1:0]         rd_char;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_fire   = m_valid_q && m_tready;

	assign dctrl.load = s_fire;
	assign dctrl.step = (state_q == ST_CONV);

	dafmt_dabble #(
		.NDIG (BCD_DIGITS)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dctrl),
		.value  (s_tdata[dafmt_pkg::VALUE_W-1:0]),
		.bcd    (bcd)
	);

	// digits above the emit window keep the leading-zero scan from running
	always_comb begin
		above = 1'b0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (i >= MAX_DIGITS) begin
				above = above | (|bcd[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W]);
			end
		end
	end

	assign ptr_dec  = ptr_q - IDX_ONE;
	// one read port: current digit while scanning, next one while emitting
	assign rd_idx   = (state_q == ST_EMIT) ? ptr_dec : ptr_q;
	assign rd_digit = bcd[rd_idx*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W];
	assign rd_char  = dafmt_pkg::CHAR_ZERO + {{(dafmt_pkg::CHAR_W-dafmt_pkg::BCD_W){1'b0}}, rd_digit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			m_valid_q <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						cnt_q   <= CNT_W'(dafmt_pkg::VALUE_W);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q - CNT_ONE;
					if (cnt_q == CNT_ONE) begin
						ptr_q   <= IDX_W'(MAX_DIGITS - 1);
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!above && ptr_q != '0 && rd_digit == '0) begin
						ptr_q <= ptr_dec;
					end else begin
						m_valid_q <= 1'b1;
						m_last_q  <= (ptr_q == '0);
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_fire) begin
						if (m_last_q) begin
							m_valid_q <= 1'b0;
							m_last_q  <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							ptr_q    <= ptr_dec;
							m_last_q <= (ptr_dec == '0);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// character register, loaded with the same timing as the control above;
	// nothing to load once the last character is taken
	always_ff @(posedge clk) begin
		if ((state_q == ST_SKIP) || (state_q == ST_EMIT && m_fire && !m_last_q)) begin
			m_char_q <= rd_char;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(dafmt_pkg::M_DATA_W-dafmt_pkg::CHAR_W){1'b0}}, m_char_q};

endmodule

// ----- rtl/dafmt_dabble.sv -----
// Iterative binary to BCD unit (shift and add 3), one input bit per step.
// Depends on dafmt_pkg.
module dafmt_dabble #(
	parameter int NDIG = dafmt_pkg::VALUE_DIGITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dafmt_pkg::dabble_ctrl_t           ctrl,
	input  logic [dafmt_pkg::VALUE_W-1:0]     value,
	output logic [NDIG*dafmt_pkg::BCD_W-1:0]  bcd
);

	logic [dafmt_pkg::VALUE_W-1:0]    bin_q;
	logic [NDIG*dafmt_pkg::BCD_W-1:0] bcd_q;
	logic [NDIG*dafmt_pkg::BCD_W-1:0] bcd_adj;

	// add 3 to every digit of 5 or more, digits are independent
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W] >= dafmt_pkg::BCD_ADJ_MIN) begin
				bcd_adj[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W] =
					bcd_q[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W] + dafmt_pkg::BCD_ADJ;
			end else begin
				bcd_adj[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W] =
					bcd_q[i*dafmt_pkg::BCD_W +: dafmt_pkg::BCD_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctrl.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (ctrl.step) begin
			bin_q <= {bin_q[dafmt_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[NDIG*dafmt_pkg::BCD_W-2:0], bin_q[dafmt_pkg::VALUE_W-1]};
		end
	end

	assign bcd = bcd_q;

endmodule

// ----- rtl/dafmt_checker.sv -----
// Port-level checks for the decimal ASCII formatter, bound to the top level.
// Depends on dafmt_pkg and decimal_ascii_formatter_unit.
module dafmt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dafmt_pkg::M_DATA_W-1:0]  m_tdata,
	input logic                            m_tlast
);

	// a stalled character holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled character changed");

	// only decimal digit codes go out
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata >= 8'(dafmt_pkg::CHAR_ZERO)) && (m_tdata <= 8'(dafmt_pkg::CHAR_NINE)))
		else $error("character out of digit range");

	// no new request while characters are pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("ready while output pending");

	// a taken request closes the input until done
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after request");

	// last character ends the run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("output continues after last character");

endmodule

bind decimal_ascii_formatter_unit dafmt_checker u_dafmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- dv/decimal_char_checker.sv -----
`timescale 1ns / 1ps
// Checker for decimal_ascii_formatter_unit: predicts the digit characters of
// every accepted request and compares them with the result stream.
// Depends on dafmt_pkg.
module decimal_char_checker #(
	parameter int MAX_DIGITS = dafmt_pkg::MAX_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [dafmt_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [dafmt_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	output int                             fail_count,
	output int                             pending_chars
);

	localparam int RADIX     = 10;
	localparam int DIGIT_BUF = 20;

	typedef struct packed {
		logic [dafmt_pkg::CHAR_W-1:0] code;
		logic                         last;
	} digit_char_t;

	digit_char_t expected_chars [$];

	// decimal digits of the low 31 bits, most significant first, clipped to
	// the MAX_DIGITS least significant ones
	function automatic void queue_decimal(input logic [dafmt_pkg::S_DATA_W-1:0] word);
		logic [dafmt_pkg::VALUE_W-1:0] rest;
		logic [dafmt_pkg::BCD_W-1:0]   dig [DIGIT_BUF];
		int                            n;
		int                            lim;
		digit_char_t                   c;
		rest = word[dafmt_pkg::VALUE_W-1:0];
		n = 0;
		do begin
			dig[n] = dafmt_pkg::BCD_W'(rest % RADIX);
			rest   = dafmt_pkg::VALUE_W'(rest / RADIX);
			n++;
		end while (rest != 0 && n < DIGIT_BUF);
		lim = MAX_DIGITS;
		if (lim < 1)
			lim = 1;
		if (lim > DIGIT_BUF)
			lim = DIGIT_BUF;
		if (n > lim)
			n = lim;
		for (int k = 0; k < n; k++) begin
			c.code = dafmt_pkg::CHAR_ZERO + dig[n-1-k];
			c.last = (k == n - 1);
			expected_chars.push_back(c);
		end
	endfunction

	always @(posedge clk) begin
		digit_char_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				queue_decimal(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected char: expected none, actual char %0d last %0b",
						$time, m_tdata[dafmt_pkg::CHAR_W-1:0], m_tlast);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata[dafmt_pkg::CHAR_W-1:0] !== want.code) begin
						$display("%0t: digit_char mismatch: expected %0d, actual %0d",
							$time, want.code, m_tdata[dafmt_pkg::CHAR_W-1:0]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_digit mismatch: expected %0b, actual %0b",
							$time, want.last, m_tlast);
						fail_count++;
					end
				end
			end
			pending_chars = expected_chars.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for decimal_ascii_formatter_unit: clock, reset, request and
// result stimulus with idling phases, watchdog and verdict.
// Depends on dafmt_pkg, the unit and decimal_char_checker.
module tb_top;

	localparam int DIGIT_LIMIT = dafmt_pkg::MAX_DIGITS_DEF;
	localparam int STALL_LIMIT = 4000;  // cycles with no transfer on either side
	localparam int LONG_HOLD   = 400;   // receiver hold-off, fills the block
	localparam int DRAIN_WAIT  = 60;    // extra wait once every character is out
	localparam int PHASE_ITEMS = 100;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [dafmt_pkg::S_DATA_W-1:0] s_tdata;   // [30:0] value, [31] pad
	logic                           m_tvalid;
	logic                           m_tready;
	logic [dafmt_pkg::M_DATA_W-1:0] m_tdata;   // [5:0] digit_char, [7:6] zero
	logic                           m_tlast;   // last_digit

	int fail_count;
	int pending_chars;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	bit hold_done;

	decimal_ascii_formatter_unit #(.MAX_DIGITS(DIGIT_LIMIT)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	decimal_char_checker #(.MAX_DIGITS(DIGIT_LIMIT)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending_chars(pending_chars)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one request; idle the sender first at the phase's rate. s_tvalid
	// is lowered here only in the idle loop, so back-to-back requests keep it high.
	task automatic send_value(input logic [dafmt_pkg::S_DATA_W-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Mostly values of a random digit count so every length shows up evenly;
	// some raw 32-bit words and some tiny ones. Bit 31 is padding and is
	// toggled at random to check it is ignored.
	function automatic logic [dafmt_pkg::S_DATA_W-1:0] random_word();
		logic [dafmt_pkg::S_DATA_W-1:0] w;
		longint                         lo;
		longint                         hi;
		int                             pick;
		int                             ndig;
		pick = $urandom_range(9);
		if (pick == 0) begin
			w = $urandom;
		end else if (pick == 1) begin
			w = $urandom_range(9);
			w[dafmt_pkg::S_DATA_W-1] = 1'($urandom_range(1));
		end else begin
			ndig = $urandom_range(1, dafmt_pkg::VALUE_DIGITS);
			lo = 1;
			repeat (ndig - 1) lo *= 10;
			hi = lo * 10 - 1;
			if (hi > 64'd2147483647)
				hi = 64'd2147483647;
			if (ndig == 1)
				lo = 0;
			w = dafmt_pkg::S_DATA_W'(lo + $urandom_range(int'(hi - lo)));
			w[dafmt_pkg::S_DATA_W-1] = 1'($urandom_range(1));
		end
		return w;
	endfunction

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n) send_value(random_word());
	endtask

	// Receiver: random stalls at the phase's rate, plus one long hold-off on
	// request from the stimulus, timed here by counting cycles.
	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: ends the run when nothing moves on either stream for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [dafmt_pkg::S_DATA_W-1:0] corner_values [$];
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		hold_req       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		corner_values  = '{
			32'd0, 32'd1, 32'd9, 32'd10, 32'd19, 32'd99, 32'd100, 32'd101,
			32'd1000, 32'd9009, 32'd12345, 32'd1000000, 32'd99999999,
			32'd100000000, 32'd999999999, 32'd1000000000, 32'd1000000007,
			32'd2000000002, 32'd1234567890, 32'd2147483647,
			32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0005
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero, digit-count boundaries, inner zeros, max value,
		// pad bit set on top of zero, max and a small value
		foreach (corner_values[i])
			send_value(corner_values[i]);

		run_phase(PHASE_ITEMS, 0, 0);
		run_phase(PHASE_ITEMS, 48, 0);
		run_phase(PHASE_ITEMS, 0, 48);
		run_phase(PHASE_ITEMS, 27, 27);

		// long receiver hold-off: the block fills with one request and must
		// hold s_tready low while the next ones are offered
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		repeat (6) send_value(random_word());

		// sender pauses until every character has come out
		s_tvalid <= 1'b0;
		while (pending_chars != 0)
			@(negedge clk);
		run_phase(30, 27, 27);

		s_tvalid <= 1'b0;
		while (pending_chars != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (fail_count == 0 && pending_chars == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
